// ===== sv/min_priority_queue_scan_top_macros.svh =====
// Assertion macros for the scan-based minimum priority queue.
`ifndef MIN_PRIORITY_QUEUE_SCAN_TOP_MACROS_SVH
`define MIN_PRIORITY_QUEUE_SCAN_TOP_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge out of reset
`define MPQS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mpqs assertion failed");

// Consequent holds in the same cycle as the antecedent
`define MPQS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpqs assertion failed");

// Consequent holds in the cycle after the antecedent
`define MPQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpqs assertion failed");

`else

`define MPQS_ASSERT_ALWAYS(lbl, cond)
`define MPQS_ASSERT_IMPLY(lbl, ante, cons)
`define MPQS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/mpqs_pkg.sv =====
// Shared types, codes and default sizes for the scan-based minimum priority queue.
`timescale 1ns / 1ps

package mpqs_pkg;

    // Default sizes
    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int TAG_BITS_DEF      = 32;

    // Field widths on the channels
    localparam int CMD_W      = 1;
    localparam int PRI_W      = 16;
    localparam int TAG_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

// ===== sv/mpqs_if.sv =====
// Request and response channel interfaces of the scan-based minimum priority queue.
`timescale 1ns / 1ps

interface mpqs_req_if
    import mpqs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [PRI_W-1:0] priority_req;
    logic [TAG_W-1:0]        tag;

    modport source (output valid, output cmd, output priority_req, output tag, input ready);
    modport sink   (input valid, input cmd, input priority_req, input tag, output ready);
endinterface

interface mpqs_rsp_if
    import mpqs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [PRI_W-1:0] removed_priority;
    logic [TAG_W-1:0]        removed_tag;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output removed_priority,
                    output removed_tag, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_priority,
                    input removed_tag, input occupancy, output ready);
endinterface

// ===== sv/min_priority_queue_scan_top.sv =====
// Bounded minimum priority queue: unsorted entry memory scanned by one comparator.
`timescale 1ns / 1ps

// A request beat either inserts (priority, tag) at the tail of an unsorted entry memory
// or removes the entry with the smallest signed priority, the oldest one on a tie; each
// request gives exactly one response beat. The block takes one request at a time and is
// not ready until the response has been moved to the output register, which then waits
// for the sink while the next request is taken. Insert, insert into a full queue and
// remove from an empty queue go from IDLE to FINISH, which loads the response. A remove
// goes from IDLE through SCAN, and through SHIFT unless the smallest entry is the newest,
// to FINISH: the single read port of the entry memory is used once per entry to scan for
// the minimum, then once per later entry to close the gap. Entries are never cleared;
// there is no clearing pass after reset.
module min_priority_queue_scan_top
    import mpqs_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = TAG_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mpqs_req_if.sink   req,
    mpqs_rsp_if.source rsp
);

`include "min_priority_queue_scan_top_macros.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Sign bit flipped so that an unsigned compare orders signed priorities
    function automatic logic [PRIORITY_BITS-1:0] order_key(input logic [PRIORITY_BITS-1:0] p);
        return {~p[PRIORITY_BITS-1], p[PRIORITY_BITS-2:0]};
    endfunction

    // Entry memories
    logic [PRIORITY_BITS-1:0] pri_mem [CAPACITY];
    logic [TAG_BITS-1:0]      tag_mem [CAPACITY];

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic                 issue_reg, issue_next;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    status_t              pend_status_reg, pend_status_next;
    logic                 rsp_vld_reg, rsp_vld_next;

    // Payload registers
    logic [PRIORITY_BITS-1:0] rd_pri_reg;
    logic [TAG_BITS-1:0]      rd_tag_reg;
    logic [PRIORITY_BITS-1:0] best_pri_reg, best_pri_next;
    logic [TAG_BITS-1:0]      best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    status_t                  rsp_status_reg;
    logic [PRI_W-1:0]         rsp_pri_reg;
    logic [TAG_W-1:0]         rsp_tag_reg;
    logic [OCC_W-1:0]         rsp_occ_reg;

    // Memory port controls
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [PRIORITY_BITS-1:0] wr_pri;
    logic [TAG_BITS-1:0]      wr_tag;

    logic             req_fire;
    logic             rsp_free;
    logic             rsp_load;
    logic [IDX_W-1:0] last_idx;
    logic             take;
    logic [IDX_W-1:0] cand_idx;
    logic             rd_last;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_vld_reg || rsp.ready;

    // Scan comparator: strict less keeps the oldest entry on a tie
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign take     = (rd_idx_reg == '0) || (order_key(rd_pri_reg) < order_key(best_pri_reg));
    assign cand_idx = take ? rd_idx_reg : best_idx_reg;
    assign rd_last  = rd_vld_reg && (rd_idx_reg == last_idx);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        issue_next       = issue_reg;
        pend_status_next = pend_status_reg;
        rsp_vld_next     = rsp_vld_reg && !rsp.ready;
        rsp_load         = 1'b0;
        best_pri_next    = best_pri_reg;
        best_tag_next    = best_tag_reg;
        best_idx_next    = best_idx_reg;
        rd_en            = 1'b0;
        rd_addr          = ptr_reg;
        wr_en            = 1'b0;
        wr_addr          = IDX_W'(count_reg);
        wr_pri           = PRIORITY_BITS'($unsigned(req.priority_req));
        wr_tag           = TAG_BITS'(req.tag);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_FINISH;
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            pend_status_next = ST_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pend_status_next = ST_REMOVED;
                        ptr_next         = '0;
                        issue_next       = 1'b1;
                        state_next       = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_vld_reg && take)
                begin
                    best_pri_next = rd_pri_reg;
                    best_tag_next = rd_tag_reg;
                    best_idx_next = rd_idx_reg;
                end
                if (rd_last)
                begin
                    if (cand_idx == last_idx)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ptr_next   = cand_idx + IDX_W'(1);
                        issue_next = 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (issue_reg)
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                end
                // Close the gap: each later entry moves down by one
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - IDX_W'(1);
                    wr_pri  = rd_pri_reg;
                    wr_tag  = rd_tag_reg;
                end
                if (rd_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_load     = 1'b1;
                    rsp_vld_next = 1'b1;
                    state_next   = S_IDLE;
                    unique case (pend_status_reg)
                        ST_INSERTED: count_next = count_reg + CNT_W'(1);
                        ST_REMOVED:  count_next = count_reg - CNT_W'(1);
                        ST_EMPTY,
                        ST_FULL:     count_next = count_reg;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            ptr_reg         <= '0;
            issue_reg       <= 1'b0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            pend_status_reg <= ST_INSERTED;
            rsp_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            issue_reg       <= issue_next;
            rd_vld_reg      <= rd_en;
            rd_idx_reg      <= rd_addr;
            pend_status_reg <= pend_status_next;
            rsp_vld_reg     <= rsp_vld_next;
        end
    end

    // Running minimum and response payload
    always_ff @(posedge clk)
    begin
        best_pri_reg <= best_pri_next;
        best_tag_reg <= best_tag_next;
        best_idx_reg <= best_idx_next;
        if (rsp_load)
        begin
            rsp_status_reg <= pend_status_reg;
            rsp_pri_reg    <= (pend_status_reg == ST_REMOVED) ? PRI_W'(best_pri_reg) : '0;
            rsp_tag_reg    <= (pend_status_reg == ST_REMOVED) ? TAG_W'(best_tag_reg) : '0;
            rsp_occ_reg    <= OCC_W'(count_next);
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pri_mem[wr_addr] <= wr_pri;
            tag_mem[wr_addr] <= wr_tag;
        end
        if (rd_en)
        begin
            rd_pri_reg <= pri_mem[rd_addr];
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    // Response channel
    assign rsp.valid            = rsp_vld_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.removed_priority = $signed(rsp_pri_reg);
    assign rsp.removed_tag      = rsp_tag_reg;
    assign rsp.occupancy        = rsp_occ_reg;

    // Checks
    `MPQS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `MPQS_ASSERT_IMPLY(a_read_in_range, rd_en, rd_addr <= last_idx)
    `MPQS_ASSERT_IMPLY(a_shift_has_gap, state_reg == S_SHIFT, best_idx_reg < last_idx)
    `MPQS_ASSERT_NEXT(a_occupancy_match, rsp_load, rsp_occ_reg == OCC_W'(count_reg))

endmodule

// ===== sim/min_queue_checker.sv =====
// Channel monitor for the minimum priority queue: predicts every response beat and checks it.
`timescale 1ns / 1ps

module min_queue_checker
    import mpqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    mpqs_req_if  req,
    mpqs_rsp_if  rsp,
    output int   mismatch_count,
    output int   pending_count,
    output int   inserted_count,
    output int   removed_count,
    output int   empty_count,
    output int   full_count
);

    typedef struct packed {
        status_t                 status;
        logic signed [PRI_W-1:0] pri;
        logic [TAG_W-1:0]        tag;
        logic [OCC_W-1:0]        occ;
    } queue_response_t;

    // Shadow copy of the queue contents, oldest entry at index 0
    logic signed [PRI_W-1:0] held_pri [CAPACITY];
    logic [TAG_W-1:0]        held_tag [CAPACITY];
    int                      held_count;
    queue_response_t         awaited_responses[$];

    initial
    begin
        held_count     = 0;
        mismatch_count = 0;
        pending_count  = 0;
        inserted_count = 0;
        removed_count  = 0;
        empty_count    = 0;
        full_count     = 0;
    end

    // Applies one request to the shadow queue and returns the response it must give
    function automatic queue_response_t serve_request(input logic [CMD_W-1:0] op,
                                                      input logic signed [PRI_W-1:0] pri,
                                                      input logic [TAG_W-1:0] tag);
        queue_response_t r;
        int              best;
        r = '{status: ST_INSERTED, pri: '0, tag: '0, occ: '0};
        if (op == CMD_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                held_pri[held_count] = pri;
                held_tag[held_count] = tag;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // strict less-than keeps the oldest entry on a tie
            best = 0;
            for (int i = 1; i < held_count; i++)
            begin
                if (held_pri[i] < held_pri[best])
                    best = i;
            end
            r.status = ST_REMOVED;
            r.pri    = held_pri[best];
            r.tag    = held_tag[best];
            // later entries close the gap
            for (int i = best; i < held_count - 1; i++)
            begin
                held_pri[i] = held_pri[i + 1];
                held_tag[i] = held_tag[i + 1];
            end
            held_count--;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    // Compares one response beat with the oldest outstanding prediction
    task automatic check_response();
        queue_response_t want;
        if (awaited_responses.size() == 0)
        begin
            $display("%0t: unexpected response beat: status %0d pri %0d tag %h occ %0d",
                     $time, rsp.status, rsp.removed_priority, rsp.removed_tag, rsp.occupancy);
            mismatch_count++;
            return;
        end
        want = awaited_responses.pop_front();
        case (want.status)
            ST_INSERTED: inserted_count++;
            ST_REMOVED:  removed_count++;
            ST_EMPTY:    empty_count++;
            default:     full_count++;
        endcase
        if (rsp.status !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            mismatch_count++;
        end
        if (rsp.removed_priority !== want.pri)
        begin
            $display("%0t: removed_priority expected %0d actual %0d",
                     $time, want.pri, rsp.removed_priority);
            mismatch_count++;
        end
        if (rsp.removed_tag !== want.tag)
        begin
            $display("%0t: removed_tag expected %h actual %h", $time, want.tag, rsp.removed_tag);
            mismatch_count++;
        end
        if (rsp.occupancy !== want.occ)
        begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, rsp.occupancy);
            mismatch_count++;
        end
    endtask

    // Requests are predicted before responses are checked in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_responses.push_back(serve_request(req.cmd, req.priority_req, req.tag));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_response();
            pending_count <= awaited_responses.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the priority queue testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module testbench
    import mpqs_pkg::*;
();

    localparam int CAPACITY        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS    = 700;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 2 * CAPACITY + 8;
    localparam int HOLD_OFF_CYCLES = 400;

    // Priorities used to fill the queue: extremes, ties and near-extremes
    localparam int SEED_PRI [16] = '{32767, -32768, 0, -32768, -1, 1, 5, 5,
                                     5, -2, 100, -100, 32767, 0, 7, -32767};

    logic        clk;
    logic        rst_n;
    logic        hold_off;
    int unsigned cycle_count;
    int          burst_left;
    int          items_sent;
    int          mismatch_count;
    int          pending_count;
    int          inserted_count;
    int          removed_count;
    int          empty_count;
    int          full_count;

    mpqs_req_if req_ch();
    mpqs_rsp_if rsp_ch();

    min_priority_queue_scan_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    min_queue_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .inserted_count (inserted_count),
        .removed_count  (removed_count),
        .empty_count    (empty_count),
        .full_count     (full_count)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Run limit
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Sends one request beat; opens a new burst after a random gap when the last one ran out
    task automatic issue_item(input cmd_t op, input logic signed [PRI_W-1:0] pri,
                              input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(99);
            if (gap < 30)
                gap = 0;
            else if (gap < 95)
                gap = $urandom_range(8, 1);
            else
                gap = $urandom_range(40, 20);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= op;
        req_ch.priority_req <= pri;
        req_ch.tag          <= tag;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    // Receiver: ready pattern changes mode after each random span
    initial
    begin
        int mode;
        int span;
        rsp_ch.ready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            mode = $urandom_range(3);
            span = $urandom_range(60, 8);
            repeat (span)
            begin
                if (hold_off)
                    rsp_ch.ready <= 1'b0;
                else
                begin
                    case (mode)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= 1'($urandom_range(1));
                        2:       rsp_ch.ready <= ($urandom_range(3) == 0);
                        default: rsp_ch.ready <= ~rsp_ch.ready;
                    endcase
                end
                @(posedge clk);
            end
        end
    end

    // One long receiver hold-off while requests keep coming
    initial
    begin
        hold_off = 1'b0;
        wait (inserted_count + removed_count >= 120);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stimulus and verdict
    initial
    begin
        logic signed [PRI_W-1:0] pri;
        cmd_t                    op;
        int                      insert_pct;
        int                      seg_len;
        int                      pick;
        int                      random_sent;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_INSERT;
        req_ch.priority_req = '0;
        req_ch.tag          = '0;
        burst_left          = 0;
        items_sent          = 0;
        random_sent         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: remove from empty, fill with extremes and ties, refuse when full, drain some
        issue_item(CMD_REMOVE, '0, '0);
        for (int i = 0; i < 16; i++)
            issue_item(CMD_INSERT, PRI_W'(SEED_PRI[i]), TAG_W'(i * 32'h1111_1111));
        issue_item(CMD_INSERT, {1'b1, {(PRI_W-1){1'b0}}}, 32'h5a5a_a5a5);
        repeat (6) issue_item(CMD_REMOVE, '1, '1);

        // Random: segments biased to fill, drain or mix
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(2);
            insert_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
            seg_len = $urandom_range(40, 10);
            repeat (seg_len)
            begin
                op   = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                pick = $urandom_range(9);
                if (pick < 4)
                    pri = PRI_W'($urandom);
                else if (pick < 8)
                    pri = PRI_W'(int'($urandom_range(8)) - 4);  // narrow range forces ties
                else if (pick == 8)
                    pri = {1'b1, {(PRI_W-1){1'b0}}};
                else
                    pri = {1'b0, {(PRI_W-1){1'b1}}};
                issue_item(op, pri, TAG_W'($urandom));
                random_sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then let the block settle
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d request beats: %0d stored, %0d refused as full,",
                 items_sent, inserted_count, full_count);
        $display("%0d removed, %0d on empty; response side held off once for %0d cycles",
                 removed_count, empty_count, HOLD_OFF_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
